// ===== sv/blg_pkg.sv =====
// Shared types and constants for the battery level gauge.
// Holds register indexes, reset values, status codes and stream field layout.
// No dependencies.
`default_nettype none

package blg_pkg;

    localparam int CFG_DATA_W  = 12;
    localparam int CFG_ADDR_W  = 3;
    localparam int MINV_W      = 12;
    localparam int CHARGE_W    = 2;
    localparam int REMAIN_W    = 3;
    localparam int OUT_FIELD_W = CHARGE_W + REMAIN_W + MINV_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_CHARGE_LEVEL  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_TOP      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_FULL    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_SEVENTY = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_FIFTY   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_TWENTY  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_TEN     = 3'd6;

    // Reset values in converter counts (count = volts * 4096 / 3.3).
    localparam logic [CFG_DATA_W-1:0] RST_CHARGE_LEVEL  = 12'd2458;
    localparam logic [CFG_DATA_W-1:0] RST_FULL_TOP      = 12'd2433;
    localparam logic [CFG_DATA_W-1:0] RST_LEVEL_FULL    = 12'd2284;
    localparam logic [CFG_DATA_W-1:0] RST_LEVEL_SEVENTY = 12'd2210;
    localparam logic [CFG_DATA_W-1:0] RST_LEVEL_FIFTY   = 12'd2148;
    localparam logic [CFG_DATA_W-1:0] RST_LEVEL_TWENTY  = 12'd2073;
    localparam logic [CFG_DATA_W-1:0] RST_LEVEL_TEN     = 12'd1999;
    localparam logic [MINV_W-1:0]     LOWEST_RESET      = 12'd2607;

    typedef enum logic [CHARGE_W-1:0] {
        CHG_DISCHARGING = 2'd0,
        CHG_CHARGING    = 2'd1,
        CHG_FINISHED    = 2'd2
    } charge_t;

    typedef enum logic [REMAIN_W-1:0] {
        REM_UNKNOWN = 3'd0,
        REM_TEN     = 3'd1,
        REM_TWENTY  = 3'd2,
        REM_FIFTY   = 3'd3,
        REM_SEVENTY = 3'd4,
        REM_FULL    = 3'd5
    } remain_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] charge_level;
        logic [CFG_DATA_W-1:0] full_top;
        logic [CFG_DATA_W-1:0] level_full;
        logic [CFG_DATA_W-1:0] level_seventy;
        logic [CFG_DATA_W-1:0] level_fifty;
        logic [CFG_DATA_W-1:0] level_twenty;
        logic [CFG_DATA_W-1:0] level_ten;
    } cfg_t;

    typedef struct packed {
        logic [MINV_W-1:0] min_voltage;
        remain_t           remain;
        charge_t           charge;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/blg_cfg_regs.sv =====
// Configuration register file for the battery level gauge thresholds.
// Depends on blg_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module blg_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rstn,
    input  wire logic                           we,
    input  wire logic [blg_pkg::CFG_ADDR_W-1:0] addr,
    input  wire logic [blg_pkg::CFG_DATA_W-1:0] wdata,
    output blg_pkg::cfg_t                       cfg
);
    import blg_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            cfg_reg.charge_level  <= RST_CHARGE_LEVEL;
            cfg_reg.full_top      <= RST_FULL_TOP;
            cfg_reg.level_full    <= RST_LEVEL_FULL;
            cfg_reg.level_seventy <= RST_LEVEL_SEVENTY;
            cfg_reg.level_fifty   <= RST_LEVEL_FIFTY;
            cfg_reg.level_twenty  <= RST_LEVEL_TWENTY;
            cfg_reg.level_ten     <= RST_LEVEL_TEN;
        end else if (we) begin
            case (addr)
                REG_CHARGE_LEVEL:  cfg_reg.charge_level  <= wdata;
                REG_FULL_TOP:      cfg_reg.full_top      <= wdata;
                REG_LEVEL_FULL:    cfg_reg.level_full    <= wdata;
                REG_LEVEL_SEVENTY: cfg_reg.level_seventy <= wdata;
                REG_LEVEL_FIFTY:   cfg_reg.level_fifty   <= wdata;
                REG_LEVEL_TWENTY:  cfg_reg.level_twenty  <= wdata;
                REG_LEVEL_TEN:     cfg_reg.level_ten     <= wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/blg_core.sv =====
// Gauge state and per-sample update: charge detection, running sum,
// constant divide for the average, minimum tracking and banding. Uses blg_pkg.
`default_nettype none

module blg_core #(
    parameter int SAMPLES_PER_AVERAGE = 20,
    parameter int ADC_BITS            = 12
) (
    input  wire logic                clk,
    input  wire logic                rstn,
    input  blg_pkg::cfg_t            cfg,
    input  wire logic                advance,
    input  wire logic [ADC_BITS-1:0] sample,
    input  wire logic                pin,
    output blg_pkg::result_t         result_next
);
    import blg_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam longint unsigned SUM_MAX =
        longint'(SAMPLES_PER_AVERAGE) * ((longint'(1) << ADC_BITS) - 1);
    localparam int SUM_W = $clog2(SUM_MAX + 1);
    // Divide by a constant through a rounded-up reciprocal; exact for every
    // sum below 2**SUM_W because 2**(DIV_SHIFT-SUM_W) is at least the divisor.
    localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam longint unsigned DIV_MUL =
        ((longint'(1) << DIV_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
    localparam int MUL_W  = $clog2(DIV_MUL + 1);
    localparam int PROD_W = SUM_W + MUL_W;
    localparam int CMP_W  = (ADC_BITS > CFG_DATA_W) ? ADC_BITS : CFG_DATA_W;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CMP_W-1:0]  lowest_reg, lowest_next;
    charge_t           charge_reg, charge_next;
    remain_t           remain_reg, remain_next;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot_full;
    logic [CMP_W-1:0]  avg;
    logic [CMP_W-1:0]  sample_ext;
    logic [CMP_W-1:0]  top_ext, full_ext, seventy_ext, fifty_ext, twenty_ext, ten_ext;
    remain_t           band;

    assign prod       = PROD_W'(sum_reg) * PROD_W'(MUL_W'(DIV_MUL));
    assign quot_full  = prod >> DIV_SHIFT;
    assign avg        = CMP_W'(quot_full[ADC_BITS-1:0]);
    assign sample_ext = CMP_W'(sample);

    assign top_ext     = CMP_W'(cfg.full_top);
    assign full_ext    = CMP_W'(cfg.level_full);
    assign seventy_ext = CMP_W'(cfg.level_seventy);
    assign fifty_ext   = CMP_W'(cfg.level_fifty);
    assign twenty_ext  = CMP_W'(cfg.level_twenty);
    assign ten_ext     = CMP_W'(cfg.level_ten);

    // Bands are tested from the top down; an average outside all of them
    // keeps the previous level.
    always_comb begin
        if (avg >= full_ext && avg < top_ext) begin
            band = REM_FULL;
        end else if (avg >= seventy_ext && avg < full_ext) begin
            band = REM_SEVENTY;
        end else if (avg >= fifty_ext && avg < seventy_ext) begin
            band = REM_FIFTY;
        end else if (avg >= twenty_ext && avg < fifty_ext) begin
            band = REM_TWENTY;
        end else if (avg >= ten_ext && avg < twenty_ext) begin
            band = REM_TEN;
        end else begin
            band = remain_reg;
        end
    end

    always_comb begin
        count_next  = count_reg;
        sum_next    = sum_reg;
        lowest_next = lowest_reg;
        charge_next = charge_reg;
        remain_next = remain_reg;
        if (sample_ext >= CMP_W'(cfg.charge_level)) begin
            // Charger attached: the running sum and count are kept as they are.
            charge_next = pin ? CHG_CHARGING : CHG_FINISHED;
            lowest_next = CMP_W'(LOWEST_RESET);
        end else begin
            charge_next = CHG_DISCHARGING;
            if (count_reg >= CNT_W'(SAMPLES_PER_AVERAGE)) begin
                // This sample is dropped; the average closes the window.
                if (avg < lowest_reg) begin
                    lowest_next = avg;
                    remain_next = band;
                end
                count_next = '0;
                sum_next   = '0;
            end else begin
                sum_next   = sum_reg + SUM_W'(sample);
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            count_reg  <= '0;
            sum_reg    <= '0;
            lowest_reg <= CMP_W'(LOWEST_RESET);
            charge_reg <= CHG_DISCHARGING;
            remain_reg <= REM_UNKNOWN;
        end else if (advance) begin
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            lowest_reg <= lowest_next;
            charge_reg <= charge_next;
            remain_reg <= remain_next;
        end
    end

    assign result_next.min_voltage = lowest_next[MINV_W-1:0];
    assign result_next.remain      = remain_next;
    assign result_next.charge      = charge_next;

endmodule

`default_nettype wire

// ===== sv/battery_level_gauge.sv =====
// A sample transfer waits in the input register; its result goes to m_tvalid from
// the output register. Throughput: one sample per cycle unless m_tready stalls.
// The output register lets a new sample enter while a result waits on m_tready.
// Reset (aresetn low, synchronous) empties both stages, restores the thresholds,
// clears sum and count, sets the minimum to 2607 counts and the states to zero.
`default_nettype none

module battery_level_gauge #(
    parameter int SAMPLES_PER_AVERAGE = 20,
    parameter int ADC_BITS            = 12
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // adc_sample [ADC_BITS-1:0], standby_pin [ADC_BITS], zero fill above
    input  wire logic [((ADC_BITS + 8) / 8) * 8 - 1:0] s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // charge_state [1:0], remain_level [4:2], min_voltage [16:5], zero fill above
    output logic [blg_pkg::OUT_TDATA_W-1:0]           m_tdata,
    input  wire logic                                 cfg_we,
    input  wire logic [blg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [blg_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import blg_pkg::*;

    logic                in_valid_reg;
    logic [ADC_BITS-1:0] in_sample_reg;
    logic                in_pin_reg;
    logic                out_valid_reg;
    result_t             out_data_reg;
    logic                advance;
    cfg_t                cfg;
    result_t             result_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    blg_cfg_regs u_cfg_regs (
        .clk   (aclk),
        .rstn  (aresetn),
        .we    (cfg_we),
        .addr  (cfg_addr),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    blg_core #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .ADC_BITS            (ADC_BITS)
    ) u_core (
        .clk         (aclk),
        .rstn        (aresetn),
        .cfg         (cfg),
        .advance     (advance),
        .sample      (in_sample_reg),
        .pin         (in_pin_reg),
        .result_next (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[ADC_BITS-1:0];
            in_pin_reg    <= s_tdata[ADC_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_data_reg.min_voltage,
                                    out_data_reg.remain,
                                    out_data_reg.charge});

endmodule

`default_nettype wire

// ===== sv/blg_checker.sv =====
// Port-level checks for battery_level_gauge, attached by the bind below.
// Depends on blg_pkg for the result field layout.
`default_nettype none

module blg_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [blg_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import blg_pkg::*;

    localparam int REM_LSB  = CHARGE_W;
    localparam int MINV_LSB = CHARGE_W + REMAIN_W;

    // A stalled result transfer keeps its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Any charger state forces the minimum back to its reset value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[CHARGE_W-1:0] != CHG_DISCHARGING)
        |-> m_tdata[MINV_LSB +: MINV_W] == LOWEST_RESET)
        else $error("minimum not reset while charging");

    // Remaining-charge level never goes past the full band.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[REM_LSB +: REMAIN_W] <= REM_FULL)
        else $error("remaining level out of range");

    // Reset empties the output stage.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind battery_level_gauge blg_checker u_blg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== sim/tb_battery_level_gauge.sv =====
// Self-checking testbench for the battery level gauge: sample transfers go in,
// each gauge reading is predicted in the bench and compared with the result stream.
// Depends on blg_pkg and the battery_level_gauge RTL.
`default_nettype none

module tb_battery_level_gauge;
    import blg_pkg::*;

    localparam int SAMPLES_PER_AVG  = 20;
    localparam int IN_TDATA_W       = 16;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int RUN_LIMIT        = 3000000;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // adc_sample [11:0], standby_pin [12], zero fill [15:13]
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // charge_state [1:0], remain_level [4:2], min_voltage [16:5], zero fill [23:17]
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Bench copy of the gauge state and thresholds.
    cfg_t              thr = {RST_CHARGE_LEVEL, RST_FULL_TOP, RST_LEVEL_FULL,
                              RST_LEVEL_SEVENTY, RST_LEVEL_FIFTY, RST_LEVEL_TWENTY,
                              RST_LEVEL_TEN};
    int unsigned       avg_count = 0;
    int unsigned       avg_sum = 0;
    logic [MINV_W-1:0] min_seen = LOWEST_RESET;
    charge_t           chg_now = CHG_DISCHARGING;
    remain_t           rem_now = REM_UNKNOWN;
    result_t           expected_readings[$];

    int fail_count = 0;
    bit src_idle   = 1'b1;
    bit sink_idle  = 1'b1;
    int sink_hold  = 0;

    battery_level_gauge dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit in_band(input logic [11:0] v, input logic [11:0] lo,
                                   input logic [11:0] hi);
        return (v >= lo) && (v < hi);
    endfunction

    // Advances the bench gauge state by one sample and returns the reading.
    function automatic result_t predict_reading(input logic [11:0] sample, input logic pin);
        logic [11:0] avg;
        result_t     r;
        if (sample >= thr.charge_level) begin
            chg_now  = pin ? CHG_CHARGING : CHG_FINISHED;
            min_seen = LOWEST_RESET;
        end else begin
            chg_now = CHG_DISCHARGING;
            if (avg_count >= SAMPLES_PER_AVG) begin
                // This call only closes the window; its own sample is dropped.
                avg = 12'(avg_sum / SAMPLES_PER_AVG);
                if (avg < min_seen) begin
                    min_seen = avg;
                    if (in_band(avg, thr.level_full, thr.full_top)) begin
                        rem_now = REM_FULL;
                    end else if (in_band(avg, thr.level_seventy, thr.level_full)) begin
                        rem_now = REM_SEVENTY;
                    end else if (in_band(avg, thr.level_fifty, thr.level_seventy)) begin
                        rem_now = REM_FIFTY;
                    end else if (in_band(avg, thr.level_twenty, thr.level_fifty)) begin
                        rem_now = REM_TWENTY;
                    end else if (in_band(avg, thr.level_ten, thr.level_twenty)) begin
                        rem_now = REM_TEN;
                    end
                end
                avg_count = 0;
                avg_sum   = 0;
            end else begin
                avg_sum   = avg_sum + int'(sample);
                avg_count = avg_count + 1;
            end
        end
        r.charge      = chg_now;
        r.remain      = rem_now;
        r.min_voltage = min_seen;
        return r;
    endfunction

    task automatic note_failure(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch on %s: expected %0d, actual %0d", what, want, got);
        end
    endtask

    // Prediction on each sample transfer, check on each result transfer.
    always @(posedge aclk) begin : reading_monitor
        result_t want;
        result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_readings.push_back(predict_reading(s_tdata[11:0], s_tdata[12]));
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[OUT_FIELD_W-1:0]);
                if (expected_readings.size() == 0) begin
                    note_failure("result without expectation", -1, int'(got));
                end else begin
                    want = expected_readings.pop_front();
                    if (got.charge !== want.charge) begin
                        note_failure("charge_state", int'(want.charge), int'(got.charge));
                    end
                    if (got.remain !== want.remain) begin
                        note_failure("remain_level", int'(want.remain), int'(got.remain));
                    end
                    if (got.min_voltage !== want.min_voltage) begin
                        note_failure("min_voltage", int'(want.min_voltage),
                                     int'(got.min_voltage));
                    end
                end
            end
        end
    end

    // Result side: random hold-off before each transfer, or a long requested stall.
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        forever begin
            gap = sink_idle ? int'($urandom_range(0, 16)) : 0;
            if (sink_hold > 0) begin
                gap       = sink_hold;
                sink_hold = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
            @(negedge aclk);
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Entered and left at a falling edge; s_tvalid stays high if the next call has no gap.
    task automatic send_sample(input logic [11:0] sample, input logic pin);
        int gap;
        gap = src_idle ? int'($urandom_range(0, 16)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {3'b000, pin, sample};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        while (expected_readings.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_addr  <= idx;
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(negedge aclk);
    endtask

    task automatic load_thresholds(input cfg_t c);
        put_reg(REG_CHARGE_LEVEL,  c.charge_level);
        put_reg(REG_FULL_TOP,      c.full_top);
        put_reg(REG_LEVEL_FULL,    c.level_full);
        put_reg(REG_LEVEL_SEVENTY, c.level_seventy);
        put_reg(REG_LEVEL_FIFTY,   c.level_fifty);
        put_reg(REG_LEVEL_TWENTY,  c.level_twenty);
        put_reg(REG_LEVEL_TEN,     c.level_ten);
        cfg_we <= 1'b0;
        thr = c;
    endtask

    // Corner values of both fields at the reset thresholds, charge edge included.
    task automatic test_field_extremes();
        send_sample(12'd0, 1'b0);
        send_sample(12'd0, 1'b1);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd4095, 1'b0);
        send_sample(RST_CHARGE_LEVEL, 1'b1);
        send_sample(RST_CHARGE_LEVEL, 1'b0);
        send_sample(RST_CHARGE_LEVEL - 12'd1, 1'b1);
    endtask

    // A window interrupted by a charger transfer, which must keep the running sum.
    task automatic test_average_window();
        repeat (8) send_sample(12'd2250, 1'($urandom_range(0, 1)));
        send_sample(12'd3000, 1'b1);
        repeat (9) send_sample(12'd2250, 1'($urandom_range(0, 1)));
        send_sample(12'd100, 1'b0);
        // A higher average next must leave the minimum and the level alone.
        repeat (21) send_sample(12'd2400, 1'b0);
        s_tvalid <= 1'b0;
        wait_idle();
    endtask

    // Random traffic under one threshold set: mostly averaging windows aimed at band
    // edges, half of them led by a charger plug event, the rest short noise bursts.
    task automatic run_threshold_phase(input cfg_t c, input int items);
        int sent;
        int target;
        int value;
        int run_len;
        int k;
        load_thresholds(c);
        sent = 0;
        while (sent < items) begin
            src_idle  = ($urandom_range(0, 4) != 0);
            sink_idle = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 3) == 0) begin
                run_len = int'($urandom_range(1, 8));
                for (k = 0; k < run_len; k++) begin
                    send_sample(12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
                end
            end else begin
                if ($urandom_range(0, 1) == 1) begin
                    send_sample(12'($urandom_range(4095, int'(c.charge_level))),
                                1'($urandom_range(0, 1)));
                    sent++;
                end
                case ($urandom_range(0, 6))
                    0: target = int'(c.full_top);
                    1: target = int'(c.level_full);
                    2: target = int'(c.level_seventy);
                    3: target = int'(c.level_fifty);
                    4: target = int'(c.level_twenty);
                    5: target = int'(c.level_ten);
                    default: target = int'($urandom_range(0, 4095));
                endcase
                target  = target + int'($urandom_range(0, 6)) - 3;
                run_len = ($urandom_range(0, 5) == 0) ? int'($urandom_range(5, 30)) : 21;
                for (k = 0; k < run_len; k++) begin
                    value = target + int'($urandom_range(0, 2)) - 1;
                    if (value < 0) value = 0;
                    if (value > 4095) value = 4095;
                    send_sample(12'(value), 1'($urandom_range(0, 1)));
                end
            end
            sent += run_len;
        end
        s_tvalid <= 1'b0;
        wait_idle();
    endtask

    task automatic test_threshold_settings();
        cfg_t c;
        c = {RST_CHARGE_LEVEL, RST_FULL_TOP, RST_LEVEL_FULL, RST_LEVEL_SEVENTY,
             RST_LEVEL_FIFTY, RST_LEVEL_TWENTY, RST_LEVEL_TEN};
        run_threshold_phase(c, 400);
        // Ordered bands below the reset minimum, so every level is reachable.
        c = {12'd3000, 12'd2600, 12'd2200, 12'd1800, 12'd1400, 12'd1000, 12'd500};
        run_threshold_phase(c, 400);
        c = '0;
        run_threshold_phase(c, 100);
        c = '1;
        run_threshold_phase(c, 250);
        repeat (2) begin
            c.charge_level  = 12'($urandom_range(0, 4095));
            c.full_top      = 12'($urandom_range(0, 4095));
            c.level_full    = 12'($urandom_range(0, 4095));
            c.level_seventy = 12'($urandom_range(0, 4095));
            c.level_fifty   = 12'($urandom_range(0, 4095));
            c.level_twenty  = 12'($urandom_range(0, 4095));
            c.level_ten     = 12'($urandom_range(0, 4095));
            run_threshold_phase(c, 250);
        end
    endtask

    // The result side stalls for a long stretch while samples keep coming.
    task automatic test_output_stall();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = SINK_HOLD_CYCLES;
        repeat (60) send_sample(12'($urandom_range(1900, 2500)), 1'($urandom_range(0, 1)));
        s_tvalid <= 1'b0;
        wait_idle();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial begin : main
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_CHARGE_LEVEL;
        cfg_wdata = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_field_extremes();
        test_average_window();
        test_threshold_settings();
        test_output_stall();
        wait_idle();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && expected_readings.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
